// File: sv/volume_chunk_map_translator_unit_defines.svh
// assertion macros for the volume chunk map translator
// used by volume_chunk_map_translator_unit, expects i_clk and i_rst_n in scope
`ifndef VOLUME_CHUNK_MAP_TRANSLATOR_UNIT_DEFINES_SVH
`define VOLUME_CHUNK_MAP_TRANSLATOR_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define VCMT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define VCMT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VCMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/vcmt_pkg.sv
// shared types and constants of the volume chunk map translator
// no dependencies
`default_nettype none

package vcmt_pkg;

    localparam int OFFSET_W  = 42;
    localparam int ADDR_W    = 43;
    localparam int DEV_W     = 48;
    localparam int SLOT_W    = 10;
    localparam int WORD_W    = 16;
    localparam int PART_W    = 4;
    localparam int SHIFT_W   = 5;
    localparam int LOW_W     = 22;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int SIZE_SH_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_MEDIA_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE  = 2'd1;

    localparam logic [SHIFT_W-1:0]   SHIFT_RESET       = 5'd22;
    localparam logic [PART_W-1:0]    PARTS_RESET       = 4'd1;
    localparam logic [SLOT_W-1:0]    SLOT_NONE         = '0;

    typedef enum logic [1:0] {
        OP_LOAD       = 2'd0,
        OP_FROM_START = 2'd1,
        OP_FROM_END   = 2'd2
    } t_opcode;

    typedef struct packed {
        logic load_ok;
        logic translate;
        logic oor;
    } t_idx_ctl;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_req;

    typedef struct packed {
        logic clearing;
    } t_mem_stat;

    // bit length of (size - 1) >> 10
    function automatic logic [SHIFT_W-1:0] chunk_shift(input logic [CFG_W-1:0] size);
        logic [CFG_W-1:0]     dec;
        logic [SIZE_SH_W-1:0] v;
        logic [SHIFT_W-1:0]   n;
        dec = size - CFG_W'(1);
        v   = dec[CFG_W-1:10];
        n   = '0;
        for (int i = 0; i < SIZE_SH_W; i++) begin
            if (v[i]) begin
                n = SHIFT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: sv/vcmt_chunk_mem.sv
// chunk map storage: one-port synchronous ram with registered read data
// clears every entry to the unmapped code after reset; uses vcmt_pkg
`default_nettype none

module vcmt_chunk_mem
    import vcmt_pkg::*;
#(
    parameter int DEPTH  = 9216,
    parameter int ADR_W  = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mem_req          i_req,
    input  wire logic [ADR_W-1:0]  i_addr,
    input  wire logic [SLOT_W-1:0] i_wdata,
    output logic      [SLOT_W-1:0] o_rdata,
    output t_mem_stat              o_stat
);

    logic [SLOT_W-1:0] r_mem [DEPTH];
    logic [SLOT_W-1:0] r_q;
    logic              r_clearing;
    logic [ADR_W-1:0]  r_clr_addr;

    logic              wr_en;
    logic [ADR_W-1:0]  wr_addr;
    logic [SLOT_W-1:0] wr_data;

    assign wr_en   = r_clearing || i_req.wr;
    assign wr_addr = r_clearing ? r_clr_addr : i_addr;
    assign wr_data = r_clearing ? SLOT_NONE : i_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_req.rd) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata         = r_q;
    assign o_stat.clearing = r_clearing;

endmodule

`default_nettype wire

// File: sv/vcmt_index.sv
// chunk index and ram address for loads and translations
// combinational, uses vcmt_pkg
`default_nettype none

module vcmt_index
    import vcmt_pkg::*;
#(
    parameter int PARTITIONS = 9,
    parameter int CHUNKS     = 1024,
    parameter int ADR_W      = 14
) (
    input  wire logic [1:0]         i_opcode,
    input  wire logic [SLOT_W-1:0]  i_slot,
    input  wire logic [WORD_W-1:0]  i_map_word,
    input  wire logic [PART_W-1:0]  i_partition,
    input  wire logic [ADDR_W-1:0]  i_addr,
    input  wire logic [SHIFT_W-1:0] i_shift,
    input  wire logic [PART_W-1:0]  i_parts_in_use,
    output t_idx_ctl                o_ctl,
    output logic      [ADR_W-1:0]   o_mem_addr,
    output logic      [LOW_W-1:0]   o_low
);

    localparam int CIW = $clog2(CHUNKS);

    logic [ADDR_W-1:0] idx_full;
    logic [PART_W-1:0] map_part;
    logic [9:0]        map_chunk;
    logic              load_ok;
    logic              translate;
    logic              oor;

    assign idx_full  = i_addr >> i_shift;
    assign map_part  = i_map_word[15:12];
    assign map_chunk = i_map_word[9:0];

    assign translate = (i_opcode == OP_FROM_START) || (i_opcode == OP_FROM_END);
    assign oor       = (int'(i_partition) >= PARTITIONS) || (idx_full >= ADDR_W'(CHUNKS));
    assign load_ok   = (i_opcode == OP_LOAD) && (i_slot != SLOT_NONE)
                       && (map_part < i_parts_in_use) && (int'(map_part) < PARTITIONS)
                       && (int'(map_chunk) < CHUNKS);

    assign o_low = i_addr[LOW_W-1:0] & ~({LOW_W{1'b1}} << i_shift);

    always_comb begin
        if (load_ok) begin
            o_mem_addr = ADR_W'(int'(map_part) * CHUNKS + int'(map_chunk));
        end else if (translate && !oor) begin
            o_mem_addr = ADR_W'(int'(i_partition) * CHUNKS + int'(idx_full[CIW-1:0]));
        end else begin
            o_mem_addr = '0;
        end
    end

    assign o_ctl.load_ok   = load_ok;
    assign o_ctl.translate = translate;
    assign o_ctl.oor       = oor;

endmodule

`default_nettype wire

// File: sv/volume_chunk_map_translator_unit.sv
// volume chunk map translator: an accepted translate transaction passes the
// stage 1, stage 2/ram and output registers to o_valid; one transaction per
// cycle while o_stall is low, loads give no result; three-stage pipeline around
// one ram (address, ram read, merge); a stalled output freezes all stages
// after reset a clearing pass writes every ram entry (PARTITIONS*CHUNKS of them,
// 9216 at defaults) with o_stall high; config writes always taken
`default_nettype none
`include "volume_chunk_map_translator_unit_defines.svh"

module volume_chunk_map_translator_unit
    import vcmt_pkg::*;
#(
    parameter int PARTITIONS = 9,
    parameter int CHUNKS     = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_opcode,
    input  wire logic [SLOT_W-1:0]    i_slot,
    input  wire logic [WORD_W-1:0]    i_map_word,
    input  wire logic [PART_W-1:0]    i_partition,
    input  wire logic [OFFSET_W-1:0]  i_offset,
    input  wire logic [OFFSET_W-1:0]  i_partition_end,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic      [DEV_W-1:0]     o_device_offset,
    output logic                      o_unmapped,
    output logic                      o_out_of_range
);

    localparam int DEPTH = PARTITIONS * CHUNKS;
    localparam int ADR_W = $clog2(DEPTH);

    logic [SHIFT_W-1:0]  r_shift;
    logic [PART_W-1:0]   r_parts;

    logic                r1_valid;
    logic [1:0]          r1_opcode;
    logic [SLOT_W-1:0]   r1_slot;
    logic [WORD_W-1:0]   r1_word;
    logic [PART_W-1:0]   r1_part;
    logic [ADDR_W-1:0]   r1_addr;

    logic                r2_valid;
    logic                r2_oor;
    logic [LOW_W-1:0]    r2_low;

    logic                r_out_valid;
    logic [DEV_W-1:0]    r_out_dev;
    logic                r_out_unm;
    logic                r_out_oor;

    logic                en;
    logic                accept;
    logic [ADDR_W-1:0]   n_addr;
    t_idx_ctl            idx_ctl;
    logic [ADR_W-1:0]    mem_addr;
    logic [LOW_W-1:0]    low;
    t_mem_req            mem_req;
    t_mem_stat           mem_stat;
    logic [SLOT_W-1:0]   mem_q;
    logic                n_unm;
    logic [DEV_W-1:0]    n_dev;

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
            r_parts <= PARTS_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MEDIA_SIZE) begin
                r_shift <= chunk_shift(i_cfg_data);
            end else if (i_cfg_index == CFG_PARTS_IN_USE) begin
                r_parts <= i_cfg_data[PART_W-1:0];
            end
        end
    end

    // pipeline control
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = mem_stat.clearing || !en;
    assign accept  = i_valid && !o_stall;

    assign n_addr = {1'b0, i_offset}
                    + ((i_opcode == OP_FROM_END) ? {1'b0, i_partition_end} : '0);

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_opcode <= i_opcode;
            r1_slot   <= i_slot;
            r1_word   <= i_map_word;
            r1_part   <= i_partition;
            r1_addr   <= n_addr;
        end
    end

    vcmt_index #(
        .PARTITIONS (PARTITIONS),
        .CHUNKS     (CHUNKS),
        .ADR_W      (ADR_W)
    ) u_index (
        .i_opcode       (r1_opcode),
        .i_slot         (r1_slot),
        .i_map_word     (r1_word),
        .i_partition    (r1_part),
        .i_addr         (r1_addr),
        .i_shift        (r_shift),
        .i_parts_in_use (r_parts),
        .o_ctl          (idx_ctl),
        .o_mem_addr     (mem_addr),
        .o_low          (low)
    );

    assign mem_req.wr = en && r1_valid && idx_ctl.load_ok;
    assign mem_req.rd = en && r1_valid && idx_ctl.translate;

    vcmt_chunk_mem #(
        .DEPTH (DEPTH),
        .ADR_W (ADR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .i_addr  (mem_addr),
        .i_wdata (r1_slot),
        .o_rdata (mem_q),
        .o_stat  (mem_stat)
    );

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid && idx_ctl.translate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r1_valid && idx_ctl.translate) begin
            r2_oor <= idx_ctl.oor;
            r2_low <= low;
        end
    end

    // merge slot and in-chunk bytes
    assign n_unm = !r2_oor && (mem_q == SLOT_NONE);
    assign n_dev = (r2_oor || n_unm) ? '0
                   : ((DEV_W'(mem_q) << r_shift) | DEV_W'(r2_low));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r2_valid) begin
            r_out_dev <= n_dev;
            r_out_unm <= n_unm;
            r_out_oor <= r2_oor;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_device_offset = r_out_dev;
    assign o_unmapped      = r_out_unm;
    assign o_out_of_range  = r_out_oor;

    `VCMT_ASSERT_IMPLIES(a_no_accept_clearing, mem_stat.clearing, o_stall, "transaction taken during clear")
    `VCMT_ASSERT_ALWAYS(a_mem_one_access, !(mem_req.wr && mem_req.rd), "ram read and write in one cycle")
    `VCMT_ASSERT_NEXT(a_freeze_holds_stage2, r_out_valid && i_stall && r2_valid, r2_valid, "stage 2 lost while output stalled")
    `VCMT_ASSERT_IMPLIES(a_flagged_zero, o_valid && (o_unmapped || o_out_of_range), o_device_offset == '0, "flagged result with nonzero offset")

endmodule

`default_nettype wire
